// ----- rtl/core/scalar_kalman_filter_core_defines.svh -----
// Assertion macros for the scalar Kalman filter core
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SKF_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SKF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/skf_pkg.sv -----
// Types and constants shared by the scalar Kalman filter core
package skf_pkg;

  localparam int unsigned EST_W      = 32;
  localparam int unsigned COV_W      = 31;
  localparam int unsigned NOISE_W    = 31;
  localparam int unsigned GAIN_BITS  = 16;
  localparam int unsigned GAIN_W     = GAIN_BITS + 1;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = GAIN_W;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 4'd3;

  typedef struct packed {
    logic signed [EST_W-1:0] measurement;
    logic                    restart;
    logic                    last_sample;
  } skf_in_item_t;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [GAIN_W-1:0]       gain;
    logic [COV_W-1:0]        covariance;
    logic [STATUS_W-1:0]     status;
    logic                    run_end;
  } skf_out_item_t;

  typedef struct packed {
    logic [NOISE_W-1:0]      process_noise;
    logic [NOISE_W-1:0]      measurement_noise;
    logic signed [EST_W-1:0] initial_estimate;
    logic [COV_W-1:0]        initial_covariance;
  } skf_cfg_t;

  typedef struct packed {
    logic capture;
    logic den;
    logic div_init;
    logic div_step;
    logic mul;
    logic commit;
  } skf_cmd_t;

  typedef struct packed {
    logic res_pending;
  } skf_stat_t;

endpackage

// ----- rtl/core/skf_intf.sv -----
// Channel interfaces for measurements, results and register writes
interface skf_in_if import skf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] measurement;
  logic                    restart;
  logic                    last_sample;

  modport source(output valid, output measurement, output restart, output last_sample,
                 input ready);
  modport sink(input valid, input measurement, input restart, input last_sample,
               output ready);
endinterface

interface skf_out_if import skf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic [GAIN_W-1:0]       gain;
  logic [COV_W-1:0]        covariance;
  logic [STATUS_W-1:0]     status;
  logic                    run_end;

  modport source(output valid, output estimate, output gain, output covariance,
                 output status, output run_end, input ready);
  modport sink(input valid, input estimate, input gain, input covariance,
               input status, input run_end, output ready);
endinterface

interface skf_cfg_if import skf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/scalar_kalman_filter_core.sv -----
// Scalar Kalman filter core, Q16.16 state with Q1.16 gain.
// The gain comes from the 17-step radix-2 gain divider; a new measurement is taken only
// while the sequencer is idle, once the previous update has been committed.
// A finished result waits in its output register while the next measurement is taken.
// Reset clears control state, loads estimate 0 and covariance one tenth, and
// returns the noise and initial registers to their reset values; no clearing pass.
module scalar_kalman_filter_core import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skf_in_if.sink    in_if,
  skf_out_if.source out_if,
  skf_cfg_if.sink   cfg_if
);

  skf_in_item_t  in_item;
  skf_out_item_t out_item;
  skf_cfg_t      cfg;
  skf_cmd_t      cmd;
  skf_stat_t     stat;

  assign in_item.measurement = in_if.measurement;
  assign in_item.restart     = in_if.restart;
  assign in_item.last_sample = in_if.last_sample;

  assign cfg_if.ready = 1'b1;

  skf_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_if.valid),
    .wr_index_i (cfg_if.index),
    .wr_data_i  (cfg_if.data),
    .cfg_o      (cfg)
  );

  skf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  skf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready)
  );

  assign out_if.estimate   = out_item.estimate;
  assign out_if.gain       = out_item.gain;
  assign out_if.covariance = out_item.covariance;
  assign out_if.status     = out_item.status;
  assign out_if.run_end    = out_item.run_end;

endmodule

// ----- rtl/core/skf_cfg.sv -----
// Configuration register file of the scalar Kalman filter core
module skf_cfg import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  input  logic [CFG_IDX_W-1:0]  wr_index_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output skf_cfg_t              cfg_o
);

  localparam logic [COV_W-1:0] TENTH = COV_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  skf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_noise      <= TENTH;
      cfg_q.measurement_noise  <= TENTH;
      cfg_q.initial_estimate   <= '0;
      cfg_q.initial_covariance <= TENTH;
    end else if (wr_valid_i) begin
      case (wr_index_i)
        CFG_PROCESS_NOISE:      cfg_q.process_noise      <= wr_data_i[NOISE_W-1:0];
        CFG_MEASUREMENT_NOISE:  cfg_q.measurement_noise  <= wr_data_i[NOISE_W-1:0];
        CFG_INITIAL_ESTIMATE:   cfg_q.initial_estimate   <= wr_data_i[EST_W-1:0];
        CFG_INITIAL_COVARIANCE: cfg_q.initial_covariance <= wr_data_i[COV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/skf_ctrl.sv -----
// Sequencer that steps the filter datapath through one update
`include "scalar_kalman_filter_core_defines.svh"

module skf_ctrl import skf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  skf_stat_t stat_i,
  output skf_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEN,
    ST_INIT,
    ST_DIV,
    ST_MUL,
    ST_UPD
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.capture  = in_valid_i;
      ST_DEN:  cmd_o.den      = 1'b1;
      ST_INIT: cmd_o.div_init = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_MUL:  cmd_o.mul      = 1'b1;
      ST_UPD:  cmd_o.commit   = !stat_i.res_pending;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_DEN;
        end
        ST_DEN: state_q <= ST_INIT;
        ST_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_q <= ST_MUL;
        end
        ST_MUL: state_q <= ST_UPD;
        ST_UPD: begin
          if (!stat_i.res_pending) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SKF_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, state_q == ST_DEN, "transfer did not start an update")
  `SKF_ASSERT_IMPL(a_cnt_range, state_q == ST_DIV, cnt_q < CNT_W'(DIV_STEPS), "divider step count overrun")
  `SKF_ASSERT_NEXT(a_div_done, state_q == ST_DIV && cnt_q == CNT_W'(DIV_STEPS - 1), state_q == ST_MUL, "divider did not finish")
  `SKF_ASSERT_IMPL(a_cmd_single, 1'b1, $onehot0(cmd_o), "more than one datapath command")

endmodule

// ----- rtl/core/skf_dp.sv -----
// Datapath: covariance predict, radix-2 gain divider, multipliers, state and result register
module skf_dp import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  skf_in_item_t  in_item_i,
  input  skf_cfg_t      cfg_i,
  input  skf_cmd_t      cmd_i,
  output skf_stat_t     stat_o,
  output skf_out_item_t out_item_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);

  localparam logic [COV_W-1:0] TENTH = COV_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam int unsigned NUM_W   = COV_W + GAIN_BITS + 1;
  localparam int unsigned DEN_W   = COV_W + 1;
  localparam int unsigned DIFF_W  = EST_W + 1;
  localparam int unsigned PX_W    = DIFF_W + GAIN_W + 1;
  localparam int unsigned PP_W    = COV_W + GAIN_W;
  localparam int unsigned DELTA_W = PX_W - GAIN_BITS;
  localparam int unsigned XN_W    = DELTA_W + 1;

  logic signed [EST_W-1:0] x_q;
  logic [COV_W-1:0]        p_q;
  logic signed [EST_W-1:0] z_q;
  logic                    run_end_q;
  logic [COV_W-1:0]        p1_q;
  logic                    sat_q;
  logic [DEN_W-1:0]        den_q;
  logic [DEN_W-1:0]        rem_q;
  logic [GAIN_W-1:0]       qs_q;
  logic signed [PX_W-1:0]  prod_x_q;
  logic [PP_W-1:0]         prod_p_q;
  skf_out_item_t           out_q;
  logic                    out_valid_q;

  logic signed [EST_W-1:0] x_src;
  logic [COV_W-1:0]        p_src;
  logic [COV_W:0]          p1_sum;
  logic [NUM_W-1:0]        num_w;
  logic [DEN_W:0]          trial_w;
  logic                    ge_w;
  logic [DEN_W:0]          sub_w;
  logic [GAIN_W-1:0]       k_w;
  logic [GAIN_W-1:0]       kc_w;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [GAIN_W:0]  ks_w;
  logic signed [PX_W-1:0]  rnd_w;
  logic [DELTA_W-1:0]      delta_w;
  logic [XN_W-1:0]         xn_w;
  logic signed [EST_W-1:0] xn_c;
  logic                    xn_ovf;
  logic [PP_W-1:0]         pn_full;
  logic [COV_W-1:0]        pn_c;
  logic                    pn_ovf;

  assign x_src  = in_item_i.restart ? cfg_i.initial_estimate : x_q;
  assign p_src  = in_item_i.restart ? cfg_i.initial_covariance : p_q;
  assign p1_sum = {1'b0, p_src} + {1'b0, cfg_i.process_noise};

  assign num_w = {1'b0, p1_q, GAIN_BITS'(0)} + NUM_W'(den_q >> 1);

  assign trial_w = {rem_q, qs_q[GAIN_W-1]};
  assign ge_w    = trial_w >= {1'b0, den_q};
  assign sub_w   = trial_w - {1'b0, den_q};

  assign k_w    = qs_q;
  assign kc_w   = (k_w > GAIN_ONE) ? GAIN_ONE : k_w;
  assign ks_w   = signed'({1'b0, kc_w});
  assign diff_w = signed'({z_q[EST_W-1], z_q}) - signed'({x_q[EST_W-1], x_q});

  assign rnd_w   = prod_x_q + PX_W'(1 << (GAIN_BITS - 1));
  assign delta_w = rnd_w[PX_W-1:GAIN_BITS];
  assign xn_w    = {{(XN_W - EST_W){x_q[EST_W-1]}}, x_q} + {delta_w[DELTA_W-1], delta_w};
  assign xn_ovf  = !((&xn_w[XN_W-1:EST_W-1]) || !(|xn_w[XN_W-1:EST_W-1]));
  assign xn_c    = !xn_ovf ? xn_w[EST_W-1:0]
                 : (xn_w[XN_W-1] ? {1'b1, {(EST_W - 1){1'b0}}} : {1'b0, {(EST_W - 1){1'b1}}});

  assign pn_full = (prod_p_q + PP_W'(1 << (GAIN_BITS - 1))) >> GAIN_BITS;
  assign pn_ovf  = |pn_full[PP_W-1:COV_W];
  assign pn_c    = pn_ovf ? {COV_W{1'b1}} : pn_full[COV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      p_q <= TENTH;
    end else if (cmd_i.capture) begin
      x_q <= x_src;
      p_q <= p_src;
    end else if (cmd_i.commit && (den_q != '0)) begin
      x_q <= xn_c;
      p_q <= pn_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      z_q       <= in_item_i.measurement;
      run_end_q <= in_item_i.last_sample;
      p1_q      <= p1_sum[COV_W] ? {COV_W{1'b1}} : p1_sum[COV_W-1:0];
      sat_q     <= p1_sum[COV_W];
    end
    if (cmd_i.den) begin
      den_q <= {1'b0, p1_q} + {1'b0, cfg_i.measurement_noise};
    end
    if (cmd_i.div_init) begin
      rem_q <= DEN_W'(num_w[NUM_W-1:GAIN_W]);
      qs_q  <= num_w[GAIN_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge_w ? sub_w[DEN_W-1:0] : trial_w[DEN_W-1:0];
      qs_q  <= {qs_q[GAIN_W-2:0], ge_w};
    end
    if (cmd_i.mul) begin
      prod_x_q <= ks_w * diff_w;
      prod_p_q <= PP_W'(GAIN_ONE - kc_w) * PP_W'(p1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.run_end <= run_end_q;
      if (den_q == '0) begin
        out_q.estimate   <= x_q;
        out_q.gain       <= '0;
        out_q.covariance <= p_q;
        out_q.status     <= STATUS_ZERO_DEN;
      end else begin
        out_q.estimate   <= xn_c;
        out_q.gain       <= kc_w;
        out_q.covariance <= pn_c;
        out_q.status     <= (sat_q || xn_ovf || pn_ovf) ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign stat_o.res_pending = out_valid_q && !out_ready_i;
  assign out_item_o         = out_q;
  assign out_valid_o        = out_valid_q;

endmodule
